// ===== src/sib_pkg.sv =====
// Package for the ranked store-record list: field widths, item kind codes,
// cell entry and control types, and the sequencer state type.
// No dependencies.
`default_nettype none

package sib_pkg;

  localparam int KIND_W   = 2;
  localparam int STORE_W  = 16;
  localparam int CODE_W   = 32;
  localparam int PRICE_W  = 32;
  localparam int VOLUME_W = 32;
  localparam int RANK_W   = 5;

  localparam int IN_DATA_W  = STORE_W + CODE_W + PRICE_W + VOLUME_W;    // 112
  localparam int OUT_FLD_W  = RANK_W + STORE_W + PRICE_W + VOLUME_W;    // 85
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;                // 88
  localparam int OUT_USER_W = 2;

  localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DUMP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [STORE_W-1:0]  store;
    logic [PRICE_W-1:0]  price;
    logic [VOLUME_W-1:0] volume;
  } entry_t;

  // Commands broadcast to every cell; at most one is high in a cycle.
  typedef struct packed {
    logic ins;
    logic rot;
    logic clr;
  } ctl_t;

  // What the sequencer needs to see of the chain.
  typedef struct packed {
    entry_t head;
    logic   second_valid;
    logic   full;
  } chain_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SPIN
  } state_t;

endpackage

`default_nettype wire

// ===== src/sib_cell.sv =====
// One cell of the insertion chain: holds one ranked entry.
// Depends on sib_pkg.
`default_nettype none

module sib_cell
  import sib_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire ctl_t   ctl,
  input  wire entry_t new_entry,
  input  wire entry_t prev_entry,
  input  wire logic   prev_cond,
  input  wire entry_t next_entry,
  output entry_t      entry,
  output logic        cond
);

  // The list is sorted descending with valid entries first, so cond is
  // low on a prefix of the chain and high on the rest.
  assign cond = !entry.valid || (entry.volume < new_entry.volume);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctl.clr) begin
      entry.valid <= 1'b0;
    end else if (ctl.rot) begin
      entry <= next_entry;
    end else if (ctl.ins && cond) begin
      if (prev_cond) begin
        entry <= prev_entry;
      end else begin
        entry <= '{valid:  1'b1,
                   store:  new_entry.store,
                   price:  new_entry.price,
                   volume: new_entry.volume};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sib_chain.sv =====
// Row of DEPTH insertion cells. Insert shifts the tail down by one cell;
// rotate moves every entry one cell toward the head, the head wrapping to the tail.
// Depends on sib_pkg and sib_cell.
`default_nettype none

module sib_chain
  import sib_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire ctl_t   ctl,
  input  wire entry_t new_entry,
  output chain_stat_t stat
);

  entry_t entries [DEPTH];
  logic   conds   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    logic   prev_c;
    entry_t next_e;

    if (i == 0) begin : g_first
      assign prev_e = new_entry;
      assign prev_c = 1'b0;
    end else begin : g_rest
      assign prev_e = entries[i-1];
      assign prev_c = conds[i-1];
    end

    assign next_e = entries[(i + 1) % DEPTH];

    sib_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_cond  (prev_c),
      .next_entry (next_e),
      .entry      (entries[i]),
      .cond       (conds[i])
    );
  end

  assign stat.head         = entries[0];
  assign stat.second_valid = entries[1].valid;
  assign stat.full         = entries[DEPTH-1].valid;

endmodule

`default_nettype wire

// ===== src/sorted_insert_by_volume_top.sv =====
// Top level of the ranked store-record list: stream ports, dump sequencer,
// output register and overflow flag around the insertion chain.
// Depends on sib_pkg and sib_chain.
//
//   Port group   Dir   Contents
//   s_*          in    request item: kind in tuser, record in tdata
//   m_*          out   ranked entry item, tlast on the final one of a dump
//   cfg_*        in    target product code register write
//
// An offer or a clear keeps the block idle, so the next item is accepted
// whenever the output is free. A dump rotates the cell chain once per cycle,
// DEPTH rotations in all, emitting the head entry on each rotation while
// entries remain; the block accepts nothing until the chain is back in order.
// An empty dump emits only the empty-list item, without rotating the chain.
// A stalled output holds the rotation. Reset is synchronous and empties the list.
`default_nettype none

module sorted_insert_by_volume_top
  import sib_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CODE_W-1:0]     cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // store_id, product_code, price, sales_volume
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // kind
  input  wire logic [KIND_W-1:0]     s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // rank, store_id_res, price_res, sales_volume_res, zero pad
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // empty_res, dropped
  output logic [OUT_USER_W-1:0]      m_tuser,
  output logic                       m_tlast
);

  localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CODE_W-1:0] target;
  logic              overflow;
  state_t            state, state_next;
  logic [KW-1:0]     k;
  ctl_t              ctl;
  chain_stat_t       stat;
  entry_t            new_entry;

  logic [KIND_W-1:0]   in_kind;
  logic [CODE_W-1:0]   in_code;
  logic                acc;
  logic                out_free;
  logic                last_now;
  logic                load_out;
  logic                load_empty;
  logic [31:0]         rank_wide;
  logic [RANK_W-1:0]   rank;

  assign in_kind          = s_tuser;
  assign new_entry.valid  = 1'b1;
  assign new_entry.store  = s_tdata[STORE_W-1:0];
  assign in_code          = s_tdata[STORE_W +: CODE_W];
  assign new_entry.price  = s_tdata[STORE_W+CODE_W +: PRICE_W];
  assign new_entry.volume = s_tdata[STORE_W+CODE_W+PRICE_W +: VOLUME_W];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign acc      = s_tvalid && s_tready;
  assign last_now = (k == KW'(DEPTH - 1)) || !stat.second_valid;

  assign rank_wide = 32'(k) + 32'd1;
  assign rank      = rank_wide[RANK_W-1:0];

  sib_chain #(.DEPTH(DEPTH)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .new_entry (new_entry),
    .stat      (stat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && in_kind == KIND_DUMP && stat.head.valid) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && last_now) begin
          state_next = (k == KW'(DEPTH - 1)) ? ST_IDLE : ST_SPIN;
        end
      end
      ST_SPIN: begin
        if (k == KW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    load_out   = 1'b0;
    load_empty = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctl.ins    = acc && in_kind == KIND_OFFER && in_code == target;
        ctl.clr    = acc && in_kind == KIND_CLEAR;
        load_empty = acc && in_kind == KIND_DUMP && !stat.head.valid;
        load_out   = load_empty;
      end
      ST_EMIT: begin
        ctl.rot  = out_free;
        load_out = out_free;
      end
      ST_SPIN: begin
        ctl.rot = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= '0;
      target   <= '0;
      overflow <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.rot) begin
        k <= (k == KW'(DEPTH - 1)) ? '0 : k + KW'(1);
      end
      if (cfg_we) target <= cfg_wdata;
      if (ctl.clr) begin
        overflow <= 1'b0;
      end else if (ctl.ins && stat.full) begin
        overflow <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (load_empty) begin
        m_tdata <= '0;
        m_tuser <= {overflow, 1'b1};
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= OUT_DATA_W'({stat.head.volume, stat.head.price,
                                stat.head.store, rank});
        m_tuser <= {overflow, 1'b0};
        m_tlast <= last_now;
      end
    end
  end

  // While emitting, the head cell always holds the next entry to send.
  a_emit_head_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> stat.head.valid)
    else $error("dump reached an empty head cell");

  // The final spin step puts the chain back in rank order and frees the input.
  a_spin_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPIN && k == KW'(DEPTH - 1)) |=> (state == ST_IDLE && k == '0))
    else $error("rotation did not finish after DEPTH steps");

  // An insert into a full list must raise the overflow flag.
  a_overflow_set: assert property (@(posedge clk) disable iff (rst)
    (ctl.ins && stat.full) |=> overflow)
    else $error("overflow flag missed on a full insert");

  // The empty-list item is always the only item of its dump.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("empty item without last");

  // No insert or clear while the chain is rotating.
  a_no_ins_in_dump: assert property (@(posedge clk) disable iff (rst)
    ctl.rot |-> (!ctl.ins && !ctl.clr && !s_tready))
    else $error("chain command overlap during dump");

endmodule

`default_nettype wire
